FILE: rtl/core/ccd_pkg.sv
// ccd_pkg: shared constants, codes and controller/datapath interface types
// for the coin change decomposer; no dependencies
package ccd_pkg;

   localparam int MAX_SUM   = 4095;
   localparam int MAX_COINS = 7;
   localparam int COIN_BITS = 12;
   localparam int SUM_BITS  = 12;
   localparam int QRY_BITS  = 16;
   localparam int RANK_BITS = 3;
   localparam int CODE_BITS = 3;
   localparam int MULT_BITS = 12;
   localparam int IDX_BITS  = 4;
   localparam int TBL_DEPTH = MAX_SUM + 1;

   localparam logic [MULT_BITS-1:0] MULT_MAX = '1;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NONE  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // register indexes
   localparam logic [IDX_BITS-1:0] CSR_COUNT  = 4'd0;
   localparam logic [IDX_BITS-1:0] CSR_COIN_0 = 4'd1;
   localparam logic [IDX_BITS-1:0] CSR_COIN_6 = 4'd7;

   typedef enum logic [1:0] {
      CODE_ZERO  = 2'd0,
      CODE_EQ    = 2'd1,
      CODE_PROBE = 2'd2
   } code_sel_type;

   typedef enum logic [9:0] {
      S_SETTLE     = 10'b00_0000_0001,
      S_IDLE       = 10'b00_0000_0010,
      S_CHECK      = 10'b00_0000_0100,
      S_FILL_EQ    = 10'b00_0000_1000,
      S_PROBE      = 10'b00_0001_0000,
      S_PROBE_CHK  = 10'b00_0010_0000,
      S_WALK_START = 10'b00_0100_0000,
      S_WALK_CHK   = 10'b00_1000_0000,
      S_EMIT       = 10'b01_0000_0000,
      S_EMIT_ONE   = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic         load_query;
      logic         init_fill;
      logic         rank_clr;
      logic         rank_inc;
      logic         tbl_wr;
      code_sel_type code_sel;
      logic         rd_probe;
      logic         rd_walk;
      logic         walk_step;
      logic         out_term;
      logic         out_single;
      logic [1:0]   single_status;
   } cmd_type;

   typedef struct packed {
      logic q_big;
      logic q_zero;
      logic n_zero;
      logic filled_ok;
      logic eq_hit;
      logic rank_end;
      logic probe_ok;
      logic rd_nz;
      logic s_eq_q;
      logic walk_first;
      logic walk_bad;
      logic walk_done;
      logic term_last;
      logic out_free;
      logic csr_wr;
   } stat_type;

endpackage

FILE: rtl/core/coin_change_decomposer.sv
// coin_change_decomposer: top level, controller plus datapath
// a check state comes first, then each new table entry is written from the
// fill state on a coin match, else after probing the coins in rank order,
// or as empty if none fits; the walk back then emits one result per coin
// throughput: one item at a time; the sum table memory port sets the fill rate
// reset: synchronous, coins and count to 1, table marked empty, then a settle state
module coin_change_decomposer import ccd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [QRY_BITS-1:0]  req_query_sum,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [COIN_BITS-1:0] rsp_coin_value,
   output logic [RANK_BITS-1:0] rsp_coin_rank,
   output logic [MULT_BITS-1:0] rsp_multiplicity,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_BITS-1:0]  csr_index,
   input  logic [COIN_BITS-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   ccd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and arithmetic
   ccd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_query_sum    (req_query_sum),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_coin_value   (rsp_coin_value),
      .rsp_coin_rank    (rsp_coin_rank),
      .rsp_multiplicity (rsp_multiplicity),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

FILE: rtl/core/ccd_ctrl.sv
// ccd_ctrl: controller state machine for the coin change decomposer
// depends on ccd_pkg
module ccd_ctrl import ccd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SETTLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !stat.csr_wr;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.code_sel = CODE_ZERO;
      cmd.single_status = ST_NONE;
      unique case (state_ff)
         S_SETTLE: begin
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (stat.csr_wr) begin
               state_in = S_SETTLE;
            end else if (req_valid) begin
               cmd.load_query = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (stat.q_big || stat.q_zero || stat.n_zero) begin
               state_in = S_EMIT_ONE;
            end else if (stat.filled_ok) begin
               state_in = S_WALK_START;
            end else begin
               cmd.init_fill = 1'b1;
               state_in = S_FILL_EQ;
            end
         end
         S_FILL_EQ: begin
            cmd.rank_clr = 1'b1;
            if (stat.eq_hit) begin
               cmd.tbl_wr = 1'b1;
               cmd.code_sel = CODE_EQ;
               state_in = stat.s_eq_q ? S_WALK_START : S_FILL_EQ;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            priority if (stat.rank_end) begin
               cmd.tbl_wr = 1'b1;
               cmd.code_sel = CODE_ZERO;
               state_in = stat.s_eq_q ? S_WALK_START : S_FILL_EQ;
            end else if (stat.probe_ok) begin
               cmd.rd_probe = 1'b1;
               state_in = S_PROBE_CHK;
            end else begin
               cmd.rank_inc = 1'b1;
            end
         end
         S_PROBE_CHK: begin
            if (stat.rd_nz) begin
               cmd.tbl_wr = 1'b1;
               cmd.code_sel = CODE_PROBE;
               state_in = stat.s_eq_q ? S_WALK_START : S_FILL_EQ;
            end else begin
               cmd.rank_inc = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_WALK_START: begin
            cmd.rd_walk = 1'b1;
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            cmd.rank_clr = 1'b1;
            priority if (!stat.rd_nz && stat.walk_first) begin
               state_in = S_EMIT_ONE;
            end else if (stat.walk_bad) begin
               state_in = S_EMIT;
            end else begin
               cmd.walk_step = 1'b1;
               state_in = stat.walk_done ? S_EMIT : S_WALK_CHK;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_term = 1'b1;
               cmd.rank_inc = 1'b1;
               if (stat.term_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT_ONE: begin
            cmd.single_status = stat.q_big ? ST_RANGE : ST_NONE;
            if (stat.out_free) begin
               cmd.out_single = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_SETTLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/ccd_dp.sv
// ccd_dp: configuration registers, coin sorter, sum table memory, walk
// counters and result register; depends on ccd_pkg
module ccd_dp import ccd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [QRY_BITS-1:0]  req_query_sum,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [COIN_BITS-1:0] rsp_coin_value,
   output logic [RANK_BITS-1:0] rsp_coin_rank,
   output logic [MULT_BITS-1:0] rsp_multiplicity,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_BITS-1:0]  csr_index,
   input  logic [COIN_BITS-1:0] csr_data
);

   logic [RANK_BITS-1:0] count_ff;
   logic [COIN_BITS-1:0] coin_ff [MAX_COINS];
   logic [COIN_BITS-1:0] sorted_ff [MAX_COINS];
   logic [COIN_BITS-1:0] sorted_in [MAX_COINS];
   logic [MULT_BITS-1:0] counts_ff [MAX_COINS];
   logic [SUM_BITS-1:0]  filled_ff, sum_ff, query_ff, walk_ff;
   logic                 big_ff;
   logic [RANK_BITS-1:0] rank_ff;
   logic [CODE_BITS-1:0] mem [TBL_DEPTH];
   logic [CODE_BITS-1:0] rd_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           status_ff;
   logic [COIN_BITS-1:0] value_ff;
   logic [RANK_BITS-1:0] orank_ff;
   logic [MULT_BITS-1:0] mult_ff;
   logic                 last_ff;

   logic                 csr_wr;
   logic                 eq_hit;
   logic [RANK_BITS-1:0] eq_rank;
   logic [COIN_BITS-1:0] rank_coin;
   logic [COIN_BITS-1:0] walk_coin;
   logic [RANK_BITS-1:0] walk_k;
   logic [SUM_BITS-1:0]  walk_rem;
   logic [SUM_BITS-1:0]  rd_addr;
   logic [CODE_BITS-1:0] wr_code;
   logic [RANK_BITS-1:0] pos [MAX_COINS];

   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid && (csr_index <= CSR_COIN_6);

   // stable descending sort: each active coin finds its position
   always_comb begin
      for (int i = 0; i < MAX_COINS; i++) begin
         sorted_in[i] = '0;
         pos[i] = '0;
      end
      for (int i = 0; i < MAX_COINS; i++) begin
         for (int j = 0; j < MAX_COINS; j++) begin
            if (RANK_BITS'(j) < count_ff && RANK_BITS'(i) < count_ff) begin
               if ((j < i && coin_ff[j] >= coin_ff[i]) ||
                   (j > i && coin_ff[j] > coin_ff[i])) begin
                  pos[i] = pos[i] + 1'b1;
               end
            end
         end
      end
      for (int i = 0; i < MAX_COINS; i++) begin
         if (RANK_BITS'(i) < count_ff) begin
            sorted_in[pos[i]] = coin_ff[i];
         end
      end
   end

   // first coin equal to the current sum
   always_comb begin
      eq_hit = 1'b0;
      eq_rank = '0;
      for (int r = MAX_COINS - 1; r >= 0; r--) begin
         if (RANK_BITS'(r) < count_ff && sorted_ff[r] == sum_ff) begin
            eq_hit = 1'b1;
            eq_rank = RANK_BITS'(r);
         end
      end
   end

   // coin selects
   assign rank_coin = (rank_ff < RANK_BITS'(MAX_COINS)) ? sorted_ff[rank_ff] : '0;
   assign walk_k    = rd_ff - 1'b1;
   assign walk_coin = (walk_k < RANK_BITS'(MAX_COINS)) ? sorted_ff[walk_k] : '0;
   assign walk_rem  = walk_ff - walk_coin;

   // table read address and write code
   always_comb begin
      priority if (cmd.rd_probe) begin
         rd_addr = sum_ff - rank_coin;
      end else if (cmd.rd_walk) begin
         rd_addr = query_ff;
      end else begin
         rd_addr = walk_rem;
      end
   end

   always_comb begin
      unique case (cmd.code_sel)
         CODE_EQ:    wr_code = eq_rank + 1'b1;
         CODE_PROBE: wr_code = rank_ff + 1'b1;
         default:    wr_code = '0;
      endcase
   end

   // sum table memory
   always_ff @(posedge clock) begin
      if (cmd.tbl_wr) begin
         mem[sum_ff] <= wr_code;
      end
      rd_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RANK_BITS'(1);
         for (int i = 0; i < MAX_COINS; i++) begin
            coin_ff[i] <= COIN_BITS'(1);
            sorted_ff[i] <= '0;
         end
         filled_ff <= '0;
         rank_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_COINS; i++) begin
            sorted_ff[i] <= sorted_in[i];
         end
         if (csr_wr) begin
            filled_ff <= '0;
            if (csr_index == CSR_COUNT) begin
               count_ff <= csr_data[RANK_BITS-1:0];
            end else begin
               coin_ff[RANK_BITS'(csr_index - CSR_COIN_0)] <= csr_data;
            end
         end else if (cmd.tbl_wr) begin
            filled_ff <= sum_ff;
         end
         if (cmd.rank_clr) begin
            rank_ff <= '0;
         end else if (cmd.rank_inc) begin
            rank_ff <= rank_ff + 1'b1;
         end
         if (cmd.out_term || cmd.out_single) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // query, walk and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         query_ff <= req_query_sum[SUM_BITS-1:0];
         big_ff <= (req_query_sum[QRY_BITS-1:SUM_BITS] != '0);
         for (int i = 0; i < MAX_COINS; i++) begin
            counts_ff[i] <= '0;
         end
      end
      if (cmd.init_fill) begin
         sum_ff <= filled_ff + 1'b1;
      end else if (cmd.tbl_wr) begin
         sum_ff <= sum_ff + 1'b1;
      end
      if (cmd.rd_walk) begin
         walk_ff <= query_ff;
      end else if (cmd.walk_step) begin
         walk_ff <= walk_rem;
         if (counts_ff[walk_k] < MULT_MAX) begin
            counts_ff[walk_k] <= counts_ff[walk_k] + 1'b1;
         end
      end
      if (cmd.out_term) begin
         status_ff <= ST_OK;
         value_ff <= rank_coin;
         orank_ff <= rank_ff;
         mult_ff <= counts_ff[rank_ff];
         last_ff <= (rank_ff == count_ff - 1'b1);
      end else if (cmd.out_single) begin
         status_ff <= cmd.single_status;
         value_ff <= '0;
         orank_ff <= '0;
         mult_ff <= '0;
         last_ff <= 1'b1;
      end
   end

   // status to the controller
   always_comb begin
      stat.q_big      = big_ff;
      stat.q_zero     = (query_ff == '0);
      stat.n_zero     = (count_ff == '0);
      stat.filled_ok  = (filled_ff >= query_ff);
      stat.eq_hit     = eq_hit;
      stat.rank_end   = (rank_ff >= count_ff);
      stat.probe_ok   = (rank_coin != '0) && (rank_coin < sum_ff);
      stat.rd_nz      = (rd_ff != '0);
      stat.s_eq_q     = (sum_ff == query_ff);
      stat.walk_first = (walk_ff == query_ff);
      stat.walk_bad   = (walk_coin == '0) || (walk_coin > walk_ff);
      stat.walk_done  = (walk_rem == '0);
      stat.term_last  = (rank_ff == count_ff - 1'b1);
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.csr_wr     = csr_wr;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_coin_value   = value_ff;
   assign rsp_coin_rank    = orank_ff;
   assign rsp_multiplicity = mult_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: rtl/core/ccd_checker.sv
// ccd_checker: port-level checks on the coin change decomposer
// depends on ccd_pkg; bound to coin_change_decomposer
module ccd_checker import ccd_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           rsp_status,
   input logic [COIN_BITS-1:0] rsp_coin_value,
   input logic [RANK_BITS-1:0] rsp_coin_rank,
   input logic [MULT_BITS-1:0] rsp_multiplicity,
   input logic                 rsp_last
);

   // a stalled item stays valid and keeps its multiplicity
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_multiplicity))
      else $error("result changed while stalled");

   // failure results are single and empty
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
      rsp_last && rsp_coin_rank == '0 && rsp_multiplicity == '0 && rsp_coin_value == '0)
      else $error("failure result not single");

   // only defined status codes
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_NONE || rsp_status == ST_RANGE)
      else $error("bad status code");

   // nothing shows right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");

endmodule

bind coin_change_decomposer ccd_checker u_ccd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_coin_value   (rsp_coin_value),
   .rsp_coin_rank    (rsp_coin_rank),
   .rsp_multiplicity (rsp_multiplicity),
   .rsp_last         (rsp_last)
);

FILE: bench/testbench.sv
// testbench: self-checking bench for coin_change_decomposer
// depends on ccd_pkg and the coin_change_decomposer rtl; checks every result
// against a behavioral predictor of the memo table and walk back
`timescale 1ns / 100ps

module testbench;
   import ccd_pkg::*;

   localparam int WATCH_LIMIT = 250000;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE_GAP  = 40;

   typedef struct {
      logic [1:0]           status;
      logic [COIN_BITS-1:0] value;
      logic [RANK_BITS-1:0] rank;
      logic [MULT_BITS-1:0] mult;
      logic                 last;
   } term_type;

   typedef enum logic {ROW_QUERY, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [QRY_BITS-1:0]  sum;
      logic [IDX_BITS-1:0]  idx;
      logic [COIN_BITS-1:0] data;
      bit                   typed;
      logic [1:0]           status;
   } row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [QRY_BITS-1:0]  req_query_sum;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_status;
   logic [COIN_BITS-1:0] rsp_coin_value;
   logic [RANK_BITS-1:0] rsp_coin_rank;
   logic [MULT_BITS-1:0] rsp_multiplicity;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [IDX_BITS-1:0]  csr_index;
   logic [COIN_BITS-1:0] csr_data;

   // predictor state
   logic [2:0]           m_count;
   logic [COIN_BITS-1:0] m_coins  [MAX_COINS];
   logic [COIN_BITS-1:0] m_sorted [MAX_COINS];
   logic [2:0]           m_table  [TBL_DEPTH];
   int                   m_filled;

   term_type pending_terms[$];
   int    error_count = 0;
   bit    hold_long   = 0;
   bit    long_busy   = 0;
   bit    no_gaps     = 0;

   coin_change_decomposer i_dut (.*);

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int used_coins();
      return (m_count > MAX_COINS) ? MAX_COINS : m_count;
   endfunction

   // stable descending sort of the slots in use, table invalidated
   function automatic void resort_coins();
      int n, j;
      logic [COIN_BITS-1:0] v;
      n = used_coins();
      foreach (m_sorted[k]) m_sorted[k] = '0;
      for (int i = 0; i < n; i++) begin
         v = m_coins[i];
         j = i;
         while (j > 0 && m_sorted[j-1] < v) begin
            m_sorted[j] = m_sorted[j-1];
            j--;
         end
         m_sorted[j] = v;
      end
      m_filled = 0;
   endfunction

   function automatic void apply_write(logic [IDX_BITS-1:0] idx, logic [COIN_BITS-1:0] data);
      if (idx == CSR_COUNT) begin
         m_count = data[2:0];
         resort_coins();
      end else if (idx <= CSR_COIN_6) begin
         m_coins[RANK_BITS'(idx - CSR_COIN_0)] = data;
         resort_coins();
      end
   endfunction

   // extend the memo table in ascending order up to sum q
   function automatic void extend_table(int q);
      int n;
      logic [2:0] code;
      n = used_coins();
      for (int s = m_filled + 1; s <= q; s++) begin
         code = 0;
         for (int r = 0; r < n; r++)
            if (code == 0 && m_sorted[r] == s) code = CODE_BITS'(r + 1);
         if (code == 0)
            for (int r = 0; r < n; r++)
               if (code == 0 && m_sorted[r] > 0 && m_sorted[r] < s
                   && m_table[s - m_sorted[r]] != 0)
                  code = CODE_BITS'(r + 1);
         m_table[s] = code;
      end
      if (q > m_filled) m_filled = q;
   endfunction

   function automatic term_type single_term(logic [1:0] st);
      term_type t;
      t.status = st;
      t.value  = '0;
      t.rank   = '0;
      t.mult   = '0;
      t.last   = 1'b1;
      return t;
   endfunction

   // decomposition terms for one query sum
   function automatic void decompose(logic [QRY_BITS-1:0] q, ref term_type terms[$]);
      int n, s, k;
      logic [MULT_BITS-1:0] counts [MAX_COINS];
      term_type t;
      n = used_coins();
      terms = {};
      foreach (counts[i]) counts[i] = '0;
      if (q > MAX_SUM) begin
         terms.push_back(single_term(ST_RANGE));
         return;
      end
      if (q == 0 || n == 0) begin
         terms.push_back(single_term(ST_NONE));
         return;
      end
      extend_table(q);
      if (m_table[q] == 0) begin
         terms.push_back(single_term(ST_NONE));
         return;
      end
      s = q;
      while (s > 0) begin
         k = (m_table[s] - 1) % MAX_COINS;
         if (m_sorted[k] == 0 || m_sorted[k] > s) break;
         if (counts[k] != MULT_MAX) counts[k]++;
         s -= m_sorted[k];
      end
      for (int r = 0; r < n; r++) begin
         t.status = ST_OK;
         t.value  = m_sorted[r];
         t.rank   = RANK_BITS'(r);
         t.mult   = counts[r];
         t.last   = (r + 1 == n);
         terms.push_back(t);
      end
   endfunction

   // offer one query item, valid held high across back-to-back items
   task automatic offer_query(logic [QRY_BITS-1:0] q, bit typed, logic [1:0] st);
      int gap;
      term_type terms[$];
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_query_sum <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decompose(q, terms);
      if (typed) pending_terms.push_back(single_term(st));
      else foreach (terms[i]) pending_terms.push_back(terms[i]);
   endtask

   // register write, valid left high for a following write
   task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [COIN_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_write(idx, data);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   function automatic logic [COIN_BITS-1:0] random_coin();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return '0;
      if (p < 25) return COIN_BITS'($urandom_range(1, 4095));
      return COIN_BITS'($urandom_range(1, 40));
   endfunction

   function automatic logic [QRY_BITS-1:0] random_sum();
      int p;
      p = $urandom_range(0, 99);
      if (p < 3) return '0;
      if (p < 8) return QRY_BITS'($urandom_range(MAX_SUM + 1, 65535));
      if (p < 11) return QRY_BITS'($urandom_range(1, MAX_SUM));
      return QRY_BITS'($urandom_range(1, 300));
   endfunction

   // result side: random stalls, one long hold-off on request
   initial begin
      int w;
      term_type e;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            hold_long = 0;
            long_busy = 1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_busy = 0;
         end else begin
            w = no_gaps ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
               rsp_ready <= 1'b0;
               repeat (w) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_terms.size() == 0) begin
            $error("unexpected result item status %0d", rsp_status);
            error_count++;
         end else begin
            e = pending_terms.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_coin_value !== e.value) begin
               $error("coin_value: expected %0d, got %0d", e.value, rsp_coin_value);
               error_count++;
            end
            if (rsp_coin_rank !== e.rank) begin
               $error("coin_rank: expected %0d, got %0d", e.rank, rsp_coin_rank);
               error_count++;
            end
            if (rsp_multiplicity !== e.mult) begin
               $error("multiplicity: expected %0d, got %0d", e.mult, rsp_multiplicity);
               error_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // directed rows, then random phases
   initial begin
      row_type rows[$];
      row_kind_type prev_kind;
      rows = '{
         '{ROW_QUERY, 16'd0,     0, 0, 1, ST_NONE},
         '{ROW_QUERY, 16'd4096,  0, 0, 1, ST_RANGE},
         '{ROW_QUERY, 16'd65535, 0, 0, 1, ST_RANGE},
         '{ROW_QUERY, 16'd1,     0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd4095,  0, 0, 0, ST_OK},
         '{ROW_WRITE, 0, CSR_COUNT,                12'hFFF,  0, ST_OK},
         '{ROW_WRITE, 0, CSR_COIN_0,               12'd4095, 0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 1), 12'd2,    0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 2), 12'd2,    0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 3), 12'd0,    0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 4), 12'd15,   0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 5), 12'd7,    0, ST_OK},
         '{ROW_WRITE, 0, CSR_COIN_6,               12'd1000, 0, ST_OK},
         '{ROW_WRITE, 0, 4'd9,                     12'd5,    0, ST_OK},
         '{ROW_QUERY, 16'd2,    0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd3,    0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd9,    0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd17,   0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd1000, 0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd4095, 0, 0, 0, ST_OK},
         '{ROW_WRITE, 0, CSR_COUNT, 12'd0, 0, ST_OK},
         '{ROW_QUERY, 16'd5,    0, 0, 1, ST_NONE},
         '{ROW_QUERY, 16'd4095, 0, 0, 1, ST_NONE},
         '{ROW_WRITE, 0, CSR_COUNT,                12'd3,    0, ST_OK},
         '{ROW_WRITE, 0, CSR_COIN_0,               12'd3,    0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 1), 12'd5,    0, ST_OK},
         '{ROW_WRITE, 0, IDX_BITS'(CSR_COIN_0 + 2), 12'd4095, 0, ST_OK},
         '{ROW_QUERY, 16'd1,    0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd7,    0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd8,    0, 0, 0, ST_OK},
         '{ROW_QUERY, 16'd4095, 0, 0, 0, ST_OK}
      };
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_query_sum = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      m_count       = 1;
      foreach (m_coins[i]) m_coins[i] = 1;
      foreach (m_table[i]) m_table[i] = '0;
      resort_coins();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      prev_kind = ROW_QUERY;
      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE) begin
            if (prev_kind == ROW_QUERY) drain();
            write_reg(rows[i].idx, rows[i].data);
         end else begin
            if (prev_kind == ROW_WRITE) csr_valid <= 1'b0;
            offer_query(rows[i].sum, rows[i].typed, rows[i].status);
         end
         prev_kind = rows[i].kind;
      end
      drain();

      // random phases, each with a fresh coin set
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_COUNT, (ph == 5) ? 12'd0 : 12'($urandom_range(1, 7)));
         for (int c = 0; c < MAX_COINS; c++)
            write_reg(IDX_BITS'(CSR_COIN_0 + c), random_coin());
         if (ph == 3) write_reg(CSR_COUNT, 12'd7);
         csr_valid <= 1'b0;
         no_gaps   = (ph == 1 || ph == 4);
         if (ph == 2) hold_long = 1;
         for (int i = 0; i < 20 + (ph == 5 ? 0 : 4); i++)
            offer_query(random_sum(), 0, ST_OK);
         drain();
      end

      while (long_busy) @(posedge clock);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
